@@ design/lma_pkg.sv @@
`timescale 1ns / 1ps
package lma_pkg;

   // Width of one sample and of one smoothed result.
   localparam int SAMPLE_W = 16;

   // Sequencer states of the top level.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_WAIT,
      ST_OUT
   } lma_state_type;

   // Commands from the sequencer to the window store.
   typedef struct packed {
      logic write;   // store the accepted sample and add it to the sum
      logic drop;    // subtract the oldest sample and advance past it
      logic clear;   // empty the window at row end
   } lma_win_cmd_type;

endpackage

@@ design/lma_window.sv @@
`timescale 1ns / 1ps
module lma_window #(
   parameter int WINDOW = 8,
   parameter int SUM_W  = 19,
   parameter int CNT_W  = 4,
   parameter int SLOT_W = 3
) (
   input  logic                             clock,
   input  logic                             reset,
   input  lma_pkg::lma_win_cmd_type         cmd,
   input  logic signed [lma_pkg::SAMPLE_W-1:0] sample,
   output logic signed [SUM_W-1:0]          sum,
   output logic [CNT_W-1:0]                 count
);

   localparam int IDX_W = ((SLOT_W > CNT_W) ? SLOT_W : CNT_W) + 1;

   logic signed [lma_pkg::SAMPLE_W-1:0] store_mem [WINDOW];
   logic signed [lma_pkg::SAMPLE_W-1:0] oldest_data_ff;

   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [SLOT_W-1:0]       oldest_ff, oldest_in;
   logic [IDX_W-1:0]        slot_raw;
   logic [SLOT_W-1:0]       wr_slot;

   // Write slot: oldest plus count, wrapped once.
   always_comb begin
      slot_raw = IDX_W'(oldest_ff) + IDX_W'(count_ff);
      if (slot_raw >= IDX_W'(WINDOW)) begin
         wr_slot = SLOT_W'(slot_raw - IDX_W'(WINDOW));
      end else begin
         wr_slot = SLOT_W'(slot_raw);
      end
   end

   always_comb begin
      sum_in    = sum_ff;
      count_in  = count_ff;
      oldest_in = oldest_ff;
      priority if (cmd.clear) begin
         sum_in    = '0;
         count_in  = '0;
         oldest_in = '0;
      end else if (cmd.write) begin
         sum_in   = sum_ff + SUM_W'(sample);
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.drop) begin
         sum_in   = sum_ff - SUM_W'(oldest_data_ff);
         count_in = count_ff - CNT_W'(1);
         if (oldest_ff == SLOT_W'(WINDOW - 1)) begin
            oldest_in = '0;
         end else begin
            oldest_in = oldest_ff + SLOT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff    <= '0;
         count_ff  <= '0;
         oldest_ff <= '0;
      end else begin
         sum_ff    <= sum_in;
         count_ff  <= count_in;
         oldest_ff <= oldest_in;
      end
   end

   // Sample store: one write port, registered read of the oldest entry.
   always_ff @(posedge clock) begin
      if (cmd.write) begin
         store_mem[wr_slot] <= sample;
      end
      oldest_data_ff <= store_mem[oldest_ff];
   end

   assign sum   = sum_ff;
   assign count = count_ff;

endmodule

@@ design/lma_divider.sv @@
`timescale 1ns / 1ps
module lma_divider #(
   parameter int SUM_W = 19,
   parameter int CNT_W = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [SUM_W-1:0]             dividend,
   input  logic [CNT_W-1:0]                    divisor,
   output logic                                done,
   output logic signed [lma_pkg::SAMPLE_W-1:0] quotient
);

   localparam int ITER_W = $clog2(SUM_W + 1);

   logic              busy_ff, busy_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              neg_ff, neg_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  div_ff, div_in;
   logic [CNT_W:0]    partial;
   logic [CNT_W:0]    diff;
   logic              take;
   logic [lma_pkg::SAMPLE_W-1:0] mag;

   // One quotient bit per cycle: shift in the next dividend bit, try subtract.
   always_comb begin
      partial = {rem_ff, quo_ff[SUM_W-1]};
      diff    = partial - {1'b0, div_ff};
      take    = (partial >= {1'b0, div_ff});
   end

   always_comb begin
      busy_in = busy_ff;
      iter_in = iter_ff;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         iter_in = ITER_W'(SUM_W);
         neg_in  = dividend[SUM_W-1];
         quo_in  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         iter_in = iter_ff - ITER_W'(1);
         quo_in  = {quo_ff[SUM_W-2:0], take};
         rem_in  = take ? CNT_W'(diff) : CNT_W'(partial);
         if (iter_ff == ITER_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = busy_ff && (iter_ff == ITER_W'(1));
   assign mag      = quo_ff[lma_pkg::SAMPLE_W-1:0];
   assign quotient = neg_ff ? $signed(-mag) : $signed(mag);

endmodule

@@ design/lookahead_moving_average.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Signals                         Meaning
// req_      in         valid, stall, sample, row_end   one sample of a row per item
// rsp_      out        valid, stall, smoothed, last    one window mean per item
//
// An item that completes no window is taken while idle. Each result takes a
// load, a bit-serial divide of the SUM_W-bit sum (19 bits at WINDOW = 8) and
// a wait in the output state until taken. A row end produces fill-count
// results one after another, and samples stall until the last is taken.
// Reset is synchronous, active high, and empties the window but not the store.
// req_stall is high while busy; a stalled result holds in the divider until taken.
module lookahead_moving_average #(
   parameter int WINDOW = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [lma_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                req_row_end,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [lma_pkg::SAMPLE_W-1:0] rsp_smoothed,
   output logic                                rsp_last
);

   // Sum of WINDOW samples, count from 0 to WINDOW, store index.
   localparam int SUM_W  = lma_pkg::SAMPLE_W + $clog2(WINDOW);
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

   lma_pkg::lma_state_type   state_ff, state_in;
   lma_pkg::lma_win_cmd_type win_cmd;

   logic                    end_ff, end_in;
   logic signed [SUM_W-1:0] win_sum;
   logic [CNT_W-1:0]        win_count;
   logic                    div_start;
   logic                    div_done;
   logic                    req_take;
   logic                    rsp_take;
   logic                    final_result;

   assign req_take     = req_valid && !req_stall;
   assign rsp_take     = rsp_valid && !rsp_stall;
   assign final_result = end_ff && (win_count == CNT_W'(1));

   lma_window #(
      .WINDOW (WINDOW),
      .SUM_W  (SUM_W),
      .CNT_W  (CNT_W),
      .SLOT_W (SLOT_W)
   ) u_window (
      .clock  (clock),
      .reset  (reset),
      .cmd    (win_cmd),
      .sample (req_sample),
      .sum    (win_sum),
      .count  (win_count)
   );

   lma_divider #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (win_sum),
      .divisor  (win_count),
      .done     (div_done),
      .quotient (rsp_smoothed)
   );

   // Next state: a full window or a row end starts a division; after each
   // result either flush further down the row or go back for samples.
   always_comb begin
      state_in = state_ff;
      end_in   = end_ff;
      unique case (state_ff)
         lma_pkg::ST_IDLE: begin
            if (req_take) begin
               end_in = req_row_end;
               if (req_row_end || (win_count == CNT_W'(WINDOW - 1))) begin
                  state_in = lma_pkg::ST_START;
               end
            end
         end
         lma_pkg::ST_START: begin
            state_in = lma_pkg::ST_WAIT;
         end
         lma_pkg::ST_WAIT: begin
            if (div_done) begin
               state_in = lma_pkg::ST_OUT;
            end
         end
         lma_pkg::ST_OUT: begin
            if (rsp_take) begin
               if (end_ff && !final_result) begin
                  state_in = lma_pkg::ST_START;
               end else begin
                  state_in = lma_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = lma_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs: hold off samples while busy; drop the oldest on each result.
   always_comb begin
      req_stall     = (state_ff != lma_pkg::ST_IDLE);
      rsp_valid     = (state_ff == lma_pkg::ST_OUT);
      rsp_last      = final_result;
      div_start     = (state_ff == lma_pkg::ST_START);
      win_cmd.write = (state_ff == lma_pkg::ST_IDLE) && req_valid;
      win_cmd.drop  = (state_ff == lma_pkg::ST_OUT) && !rsp_stall;
      win_cmd.clear = (state_ff == lma_pkg::ST_OUT) && !rsp_stall && final_result;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lma_pkg::ST_IDLE;
         end_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         end_ff   <= end_in;
      end
   end

endmodule

@@ bench/lookahead_moving_average_tb.sv @@
`timescale 1ns / 1ps
module lookahead_moving_average_tb;

   localparam int SAMPLE_W   = lma_pkg::SAMPLE_W;
   localparam int WINDOW     = 8;
   localparam int SUM_W      = 19;
   // Per-result allowance for the drain wait: load, divide, output.
   localparam int MEAN_CYCLES = SUM_W + 2;
   // Give up after this many cycles in a row with no item on either channel.
   localparam int IDLE_LIMIT  = 3000;
   // Length of the deliberate receiver hold-off.
   localparam int LONG_HOLD   = 400;
   localparam int RANDOM_ITEMS = 180;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] smoothed;
      logic                       last;
   } mean_item_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic                       req_row_end = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_smoothed;
   logic                       rsp_last;

   lookahead_moving_average #(.WINDOW(WINDOW)) uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample   (req_sample),
      .req_row_end  (req_row_end),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_smoothed (rsp_smoothed),
      .rsp_last     (rsp_last)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Own copy of the window: pending samples, their exact sum and position.
   logic signed [SAMPLE_W-1:0] window_q [WINDOW];
   logic signed [SUM_W-1:0]    sum_q = '0;
   logic [3:0]                 count_q = '0;
   logic [2:0]                 oldest_q = '0;

   mean_item_type pending_means[$];

   int  items_sent    = 0;
   int  rows_sent     = 0;
   int  means_checked = 0;
   int  mismatches    = 0;
   int  burst_left    = 0;
   bit  hold_request  = 1'b0;
   bit  hold_done     = 1'b0;

   // Queue the mean of the pending samples, then drop the oldest one.
   task automatic push_mean(input int divisor, input logic is_last);
      mean_item_type m;
      int            q;
      q = int'(sum_q) / divisor;   // truncates toward zero
      m.smoothed = q[SAMPLE_W-1:0];
      m.last     = is_last;
      pending_means.push_back(m);
      sum_q    = sum_q - window_q[oldest_q];
      oldest_q = oldest_q + 3'd1;
      count_q  = count_q - 4'd1;
   endtask

   // Work out every mean that one accepted sample releases.
   task automatic predict_means(input logic signed [SAMPLE_W-1:0] s, input logic row_end);
      logic [2:0] slot;
      slot = 3'((int'(oldest_q) + int'(count_q)) % WINDOW);
      window_q[slot] = s;
      sum_q   = sum_q + SUM_W'(s);
      count_q = count_q + 4'd1;
      if (row_end) begin
         // Flush the shrinking windows, last flag on the final one only.
         while (count_q > 0) push_mean(int'(count_q), count_q == 4'd1);
         sum_q    = '0;
         count_q  = '0;
         oldest_q = '0;
      end else if (count_q == WINDOW) begin
         push_mean(WINDOW, 1'b0);
      end
   endtask

   // Offer one item, in bursts with random gaps, and hold it until taken.
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic row_end);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_sample  <= s;
      req_row_end <= row_end;
      do @(posedge clock); while (req_stall);
      predict_means(s, row_end);
      items_sent++;
      if (row_end) rows_sent++;
   endtask

   // Mostly arbitrary values, with the extremes and small values mixed in.
   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return 16'sh7fff;
         1:       return 16'sh8000;
         2:       return SAMPLE_W'($urandom_range(0, 20)) - 16'sd10;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // Receiver: stall on a pattern that changes every so often, or hold off
   // for a long stretch when asked to.
   initial begin
      int  hold_left;
      int  mode;
      int  mode_left;
      logic stall_next;
      hold_left = 0;
      mode = 0;
      mode_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 80);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
            if (hold_left == 0) hold_done = 1'b1;
         end else begin
            case (mode)
               0:       stall_next = 1'b0;
               1:       stall_next = ($urandom_range(0, 3) == 0);
               default: stall_next = ($urandom_range(0, 3) != 0);
            endcase
         end
         rsp_stall <= stall_next;
      end
   end

   // Compare each accepted result with the oldest expected mean.
   initial begin
      mean_item_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            means_checked++;
            if (pending_means.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: smoothed %0d last %0b",
                           rsp_smoothed, rsp_last);
            end else begin
               want = pending_means.pop_front();
               if (rsp_smoothed !== want.smoothed || rsp_last !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result %0d: expected smoothed %0d last %0b, got %0d last %0b",
                              means_checked, want.smoothed, want.last,
                              rsp_smoothed, rsp_last);
               end
            end
         end
      end
   end

   // Watchdog: count cycles in which neither channel moves an item.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      @(negedge reset);
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("lookahead_moving_average: mismatch");
      $finish;
   end

   // Rows of one sample: the mean is the sample itself, with last set.
   task automatic test_single_sample_rows();
      send_sample(16'sh7fff, 1'b1);
      send_sample(16'sh8000, 1'b1);
      send_sample(16'sd0, 1'b1);
      send_sample(-16'sd1, 1'b1);
   endtask

   // A row shorter than the window, and a row of exactly one window at the
   // negative extreme, so the sum reaches its lowest value.
   task automatic test_short_and_full_rows();
      repeat (2) send_sample(16'sh7fff, 1'b0);
      send_sample(16'sh7fff, 1'b1);
      repeat (WINDOW - 1) send_sample(16'sh8000, 1'b0);
      send_sample(16'sh8000, 1'b1);
   endtask

   // A row longer than the window with small mixed-sign values, so that
   // negative means must truncate toward zero.
   task automatic test_truncation_row();
      send_sample(-16'sd1, 1'b0);
      send_sample(-16'sd2, 1'b0);
      send_sample(16'sd3, 1'b0);
      send_sample(-16'sd7, 1'b0);
      send_sample(16'sd0, 1'b0);
      send_sample(-16'sd5, 1'b0);
      send_sample(16'sd1, 1'b0);
      send_sample(-16'sd4, 1'b0);
      send_sample(16'sd6, 1'b0);
      send_sample(-16'sd3, 1'b1);
   endtask

   // Random rows: mostly short or a little over one window, a few long.
   task automatic test_random_rows();
      int start_items;
      int row_len;
      start_items = items_sent;
      while (items_sent - start_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3:    row_len = $urandom_range(1, WINDOW - 1);
            4, 5, 6, 7:    row_len = $urandom_range(WINDOW, 20);
            8:             row_len = WINDOW;
            default:       row_len = $urandom_range(21, 40);
         endcase
         for (int i = 0; i < row_len; i++)
            send_sample(pick_sample(), i == row_len - 1);
      end
   endtask

   // Hold the receiver off while the sender keeps offering a long row, so
   // the result register fills and the input stalls.
   task automatic test_backpressure();
      wait (pending_means.size() == 0);
      hold_request = 1'b1;
      for (int i = 0; i < 20; i++)
         send_sample(pick_sample(), i == 19);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_single_sample_rows();
      test_short_and_full_rows();
      test_truncation_row();
      test_random_rows();
      test_backpressure();
      req_valid <= 1'b0;
      // Drain: wait for every expected mean, then watch for stray results.
      while (pending_means.size() != 0) @(posedge clock);
      repeat (4 * MEAN_CYCLES) @(posedge clock);
      $display("sent %0d samples in %0d rows, checked %0d means, %0d mismatches",
               items_sent, rows_sent, means_checked, mismatches);
      $display("long receiver hold-off %s", hold_done ? "completed" : "not completed");
      if (mismatches == 0 && pending_means.size() == 0) begin
         $display("lookahead_moving_average: match");
      end else begin
         $display("lookahead_moving_average: mismatch");
      end
      $finish;
   end

endmodule
